// File: hw/rtl/mecanum_kinematics_defines.svh
// Assertion macros shared by the mecanum kinematics checkers.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MECANUM_KINEMATICS_DEFINES_SVH
`define MECANUM_KINEMATICS_DEFINES_SVH

// Checked on every rising edge outside reset.
`define MK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, during reset too.
`define MK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/mkin_pkg.sv
// Package for the mecanum kinematics block: word types, register codes,
// fixed-point constants and the rounding and saturating helpers.
`timescale 1ns / 1ps

package mkin_pkg;

  // Angle resolution kept from the heading.
  localparam int ANGLE_BITS = 16;
  localparam int DROP_BITS  = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam logic [15:0] HEADING_MASK = 16'(32'hFFFF << DROP_BITS);

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] POLY_A  = 31'd1686629713;
  localparam logic [29:0] POLY_B  = 30'd688904866;
  localparam logic [26:0] POLY_C  = 27'd76016977;

  // Cycles from an accepted request word to its result strobe.
  localparam int LATENCY = 8;

  // Register reset values.
  localparam logic [31:0] WHEEL_RADIUS_RST     = 32'd3277;
  localparam logic [31:0] INV_WHEEL_RADIUS_RST = 32'd1310720;
  localparam logic [31:0] TRACK_SUM_RST        = 32'd26214;
  localparam logic [31:0] INV_TRACK_SUM_RST    = 32'd163840;

  typedef enum logic [1:0] {
    REG_WHEEL_RADIUS     = 2'd0,
    REG_INV_WHEEL_RADIUS = 2'd1,
    REG_TRACK_SUM        = 2'd2,
    REG_INV_TRACK_SUM    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_FORWARD = 1'b0,
    KIND_INVERSE = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        heading;
    logic signed [31:0] wheel_speed_1;
    logic signed [31:0] wheel_speed_2;
    logic signed [31:0] wheel_speed_3;
    logic signed [31:0] wheel_speed_4;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_turn;
  } req_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_turn;
    logic signed [31:0] out_wheel_1;
    logic signed [31:0] out_wheel_2;
    logic signed [31:0] out_wheel_3;
    logic signed [31:0] out_wheel_4;
  } result_t;

  // Clamps a sign and magnitude to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic neg, input logic [67:0] q);
    logic signed [31:0] r;
    if (neg) begin
      if (q > 68'h0_8000_0000) r = 32'sh8000_0000;
      else r = 32'(68'd0 - q);
    end else begin
      if (q > 68'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

  // Rounds a * b / 2^k half away from zero and saturates; 1 <= k <= 32.
  function automatic logic signed [31:0] mul_sat(input logic signed [35:0] a,
                                                 input logic [31:0] b, input int k);
    logic [35:0] m;
    logic [67:0] prod;
    logic [67:0] q;
    m    = a[35] ? (~a + 36'd1) : a;
    prod = {32'd0, m} * {36'd0, b};
    q    = (prod >> k) + 68'(prod[k-1]);
    return sat32(a[35], q);
  endfunction

  // Rounds v / 2^16 half away from zero and saturates.
  function automatic logic signed [31:0] rnd_sat16(input logic signed [49:0] v);
    logic [49:0] m;
    logic [67:0] q;
    m = v[49] ? (~v + 50'd1) : v;
    q = 68'(m >> 16) + 68'(m[15]);
    return sat32(v[49], q);
  endfunction

endpackage

// File: hw/rtl/mecanum_kinematics.sv
// Mecanum wheel kinematics, forward and inverse, as an eight-stage pipeline.
// Depends on mkin_pkg and mkin_sincos.
//
//   channel   handshake                  word
//   request   start / busy               req_i    (mkin_pkg::req_t)
//   result    done_o strobe, no stall    result_o (mkin_pkg::result_t)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request word is taken every cycle; busy stays low.
// Each result passes through the five-stage sine and cosine polynomial,
// followed by the rotation, rounding and wheel products. Reset clears the
// stage valid bits and loads the register defaults.
// The result side has no back pressure, so the pipeline never holds.
`timescale 1ns / 1ps

module mecanum_kinematics (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mkin_pkg::req_t      req_i,
  output logic                done_o,
  output mkin_pkg::result_t   result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic [31:0] wheel_radius_q, inv_wheel_radius_q, track_sum_q, inv_track_sum_q;
  logic [mkin_pkg::LATENCY-1:0] vld_q;

  logic signed [17:0] sin_w, cos_w;

  logic               kind_q [7];
  logic signed [34:0] fs0_q, fs1_q, fs2_q;
  logic signed [31:0] vx1_q, vy1_q, vt1_q;
  logic signed [31:0] p_q [4];
  logic signed [31:0] q_q [4];
  logic signed [31:0] t_q [6];
  logic signed [49:0] cp_q, sq_q, sp_q, cq_q;
  logic signed [31:0] x7_q, y7_q;

  logic signed [49:0] xsum, ysum;
  mkin_pkg::result_t  res_d;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_radius_q     <= mkin_pkg::WHEEL_RADIUS_RST;
      inv_wheel_radius_q <= mkin_pkg::INV_WHEEL_RADIUS_RST;
      track_sum_q        <= mkin_pkg::TRACK_SUM_RST;
      inv_track_sum_q    <= mkin_pkg::INV_TRACK_SUM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mkin_pkg::cfg_reg_e'(cfg_index_i))
        mkin_pkg::REG_WHEEL_RADIUS:     wheel_radius_q     <= cfg_data_i;
        mkin_pkg::REG_INV_WHEEL_RADIUS: inv_wheel_radius_q <= cfg_data_i;
        mkin_pkg::REG_TRACK_SUM:        track_sum_q        <= cfg_data_i;
        mkin_pkg::REG_INV_TRACK_SUM:    inv_track_sum_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[mkin_pkg::LATENCY-2:0], start && !busy};
    end
  end

  assign done_o = vld_q[mkin_pkg::LATENCY-1];

  mkin_sincos u_sincos (
    .clk_i    (clk_i),
    .heading_i(req_i.heading),
    .sin_o    (sin_w),
    .cos_o    (cos_w)
  );

  // Rotation sums: the inverse direction uses the transposed rotation.
  always_comb begin
    if (kind_q[5] == mkin_pkg::KIND_INVERSE) begin
      xsum = cp_q + sq_q;
      ysum = cq_q - sp_q;
    end else begin
      xsum = cp_q - sq_q;
      ysum = cq_q + sp_q;
    end
  end

  // Final stage: body velocities for forward words, wheel products for inverse words.
  always_comb begin
    res_d             = '0;
    res_d.result_kind = kind_q[6];
    if (kind_q[6] == mkin_pkg::KIND_INVERSE) begin
      res_d.out_wheel_1 = mkin_pkg::mul_sat(36'(x7_q) - 36'(y7_q) - 36'(t_q[5]),
                                            inv_wheel_radius_q, 16);
      res_d.out_wheel_2 = mkin_pkg::mul_sat(36'(x7_q) + 36'(y7_q) + 36'(t_q[5]),
                                            inv_wheel_radius_q, 16);
      res_d.out_wheel_3 = mkin_pkg::mul_sat(36'(x7_q) + 36'(y7_q) - 36'(t_q[5]),
                                            inv_wheel_radius_q, 16);
      res_d.out_wheel_4 = mkin_pkg::mul_sat(36'(x7_q) - 36'(y7_q) + 36'(t_q[5]),
                                            inv_wheel_radius_q, 16);
    end else begin
      res_d.out_vel_x    = x7_q;
      res_d.out_vel_y    = y7_q;
      res_d.out_vel_turn = t_q[5];
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk_i) begin
    // Stage 1: wheel sums and velocity capture.
    kind_q[0] <= req_i.req_type;
    fs0_q <= 35'(req_i.wheel_speed_1) + 35'(req_i.wheel_speed_2)
           + 35'(req_i.wheel_speed_3) + 35'(req_i.wheel_speed_4);
    fs1_q <= -35'(req_i.wheel_speed_1) + 35'(req_i.wheel_speed_2)
           + 35'(req_i.wheel_speed_3) - 35'(req_i.wheel_speed_4);
    fs2_q <= -35'(req_i.wheel_speed_1) + 35'(req_i.wheel_speed_2)
           - 35'(req_i.wheel_speed_3) + 35'(req_i.wheel_speed_4);
    vx1_q <= req_i.vel_x;
    vy1_q <= req_i.vel_y;
    vt1_q <= req_i.vel_turn;

    // Stage 2: radius products, or the turn lever arm.
    kind_q[1] <= kind_q[0];
    if (kind_q[0] == mkin_pkg::KIND_INVERSE) begin
      p_q[0] <= vx1_q;
      q_q[0] <= vy1_q;
      t_q[0] <= mkin_pkg::mul_sat(36'(vt1_q), track_sum_q, 16);
    end else begin
      p_q[0] <= mkin_pkg::mul_sat(36'(fs0_q), wheel_radius_q, 18);
      q_q[0] <= mkin_pkg::mul_sat(36'(fs1_q), wheel_radius_q, 18);
      t_q[0] <= mkin_pkg::mul_sat(36'(fs2_q), wheel_radius_q, 18);
    end

    // Stage 3: body turn rate for forward words.
    kind_q[2] <= kind_q[1];
    p_q[1]    <= p_q[0];
    q_q[1]    <= q_q[0];
    t_q[1]    <= (kind_q[1] == mkin_pkg::KIND_INVERSE) ? t_q[0]
               : mkin_pkg::mul_sat(36'(t_q[0]), inv_track_sum_q, 16);

    // Stages 4 and 5: wait for sine and cosine.
    kind_q[3] <= kind_q[2];
    p_q[2]    <= p_q[1];
    q_q[2]    <= q_q[1];
    t_q[2]    <= t_q[1];
    kind_q[4] <= kind_q[3];
    p_q[3]    <= p_q[2];
    q_q[3]    <= q_q[2];
    t_q[3]    <= t_q[2];

    // Stage 6: rotation products.
    kind_q[5] <= kind_q[4];
    cp_q      <= 50'(cos_w) * 50'(p_q[3]);
    sq_q      <= 50'(sin_w) * 50'(q_q[3]);
    sp_q      <= 50'(sin_w) * 50'(p_q[3]);
    cq_q      <= 50'(cos_w) * 50'(q_q[3]);
    t_q[4]    <= t_q[3];

    // Stage 7: round and saturate the rotated pair.
    kind_q[6] <= kind_q[5];
    x7_q      <= mkin_pkg::rnd_sat16(xsum);
    y7_q      <= mkin_pkg::rnd_sat16(ysum);
    t_q[5]    <= t_q[4];

    // Stage 8: result register.
    result_o  <= res_d;
  end

endmodule

// File: hw/rtl/mkin_sincos.sv
// Five-stage pipelined sine and cosine of the heading, Q16 results.
// Depends on mkin_pkg for the polynomial constants and angle mask.
`timescale 1ns / 1ps

module mkin_sincos (
  input  logic               clk_i,
  input  logic [15:0]        heading_i,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o
);

  logic [15:0] h;
  logic [1:0]  qs, qc;
  logic [29:0] xr;
  logic [30:0] xs_d, xc_d;

  logic [30:0] xs1_q, xc1_q, xs2_q, xc2_q, xs3_q, xc3_q, xs4_q, xc4_q;
  logic [3:0]  neg_q [4];
  logic [30:0] x2s_q, x2c_q, x2s3_q, x2c3_q;
  logic [29:0] ubs_q, ubc_q;
  logic [30:0] uas_q, uac_q;

  logic [61:0] sq_s, sq_c;
  logic [57:0] p1s, p1c;
  logic [60:0] p2s, p2c;
  logic [61:0] p3s, p3c;
  logic [30:0] u3s, u3c;
  logic [16:0] vs, vc;

  // Quadrant folding: cosine is the sine a quarter turn later.
  always_comb begin
    h    = heading_i & mkin_pkg::HEADING_MASK;
    qs   = h[15:14];
    qc   = qs + 2'd1;
    xr   = {h[13:0], 16'd0};
    xs_d = qs[0] ? (mkin_pkg::Q30_ONE - {1'b0, xr}) : {1'b0, xr};
    xc_d = qc[0] ? (mkin_pkg::Q30_ONE - {1'b0, xr}) : {1'b0, xr};
  end

  // Polynomial terms, one product per stage.
  always_comb begin
    sq_s = {31'd0, xs1_q} * {31'd0, xs1_q};
    sq_c = {31'd0, xc1_q} * {31'd0, xc1_q};
    p1s  = {27'd0, x2s_q} * {31'd0, mkin_pkg::POLY_C};
    p1c  = {27'd0, x2c_q} * {31'd0, mkin_pkg::POLY_C};
    p2s  = {30'd0, x2s3_q} * {31'd0, ubs_q};
    p2c  = {30'd0, x2c3_q} * {31'd0, ubc_q};
    p3s  = {31'd0, xs4_q} * {31'd0, uas_q};
    p3c  = {31'd0, xc4_q} * {31'd0, uac_q};
    u3s  = p3s[60:30];
    u3c  = p3c[60:30];
    vs   = 17'((u3s + 31'd8192) >> 14);
    vc   = 17'((u3c + 31'd8192) >> 14);
  end

  // Pipeline registers; the sign bits ride along with the data.
  always_ff @(posedge clk_i) begin
    xs1_q     <= xs_d;
    xc1_q     <= xc_d;
    neg_q[0]  <= {2'b00, qc[1], qs[1]};
    x2s_q     <= sq_s[60:30];
    x2c_q     <= sq_c[60:30];
    xs2_q     <= xs1_q;
    xc2_q     <= xc1_q;
    neg_q[1]  <= neg_q[0];
    ubs_q     <= mkin_pkg::POLY_B - 30'(p1s[57:30]);
    ubc_q     <= mkin_pkg::POLY_B - 30'(p1c[57:30]);
    x2s3_q    <= x2s_q;
    x2c3_q    <= x2c_q;
    xs3_q     <= xs2_q;
    xc3_q     <= xc2_q;
    neg_q[2]  <= neg_q[1];
    uas_q     <= mkin_pkg::POLY_A - p2s[60:30];
    uac_q     <= mkin_pkg::POLY_A - p2c[60:30];
    xs4_q     <= xs3_q;
    xc4_q     <= xc3_q;
    neg_q[3]  <= neg_q[2];
    sin_o     <= neg_q[3][0] ? -$signed({1'b0, vs}) : $signed({1'b0, vs});
    cos_o     <= neg_q[3][1] ? -$signed({1'b0, vc}) : $signed({1'b0, vc});
  end

endmodule

// File: hw/rtl/mkin_checker.sv
// Port-level checks for the mecanum kinematics block, bound to its top level.
// Depends on mkin_pkg and mecanum_kinematics_defines.svh.
`timescale 1ns / 1ps
`include "mecanum_kinematics_defines.svh"

module mkin_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input mkin_pkg::req_t    req_i,
  input logic              done_o,
  input mkin_pkg::result_t result_o
);

  // A result follows its request by the fixed pipeline depth.
  `MK_ASSERT(a_done_latency, done_o |-> $past(start && !busy, mkin_pkg::LATENCY), "result without request")

  // The result kind echoes the request type from the same word.
  `MK_ASSERT(a_kind_echo, done_o |-> (result_o.result_kind == $past(req_i.req_type, mkin_pkg::LATENCY)), "kind mismatch")

  // Forward results leave the wheel fields at zero.
  `MK_ASSERT(a_fwd_zero, (done_o && !result_o.result_kind) |-> (result_o.out_wheel_1 == 0 && result_o.out_wheel_2 == 0 && result_o.out_wheel_3 == 0 && result_o.out_wheel_4 == 0), "forward wheels not zero")

  // Inverse results leave the velocity fields at zero.
  `MK_ASSERT(a_inv_zero, (done_o && result_o.result_kind) |-> (result_o.out_vel_x == 0 && result_o.out_vel_y == 0 && result_o.out_vel_turn == 0), "inverse velocities not zero")

endmodule

bind mecanum_kinematics mkin_checker u_mkin_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .done_o  (done_o),
  .result_o(result_o)
);
